// ===== rtl/assert_macros.svh =====
// ============================================================================
// assert_macros.svh
// Assertion macros shared by the checker module of the box filter.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define BFS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Clocked assertion that also holds through reset.
`define BFS_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bfs_pkg.sv =====
// ============================================================================
// bfs_pkg
// Types and fixed constants of the box filter: register map, field widths,
// sequencer states and the operation codes of the shared arithmetic unit.
// ============================================================================
`default_nettype none

package bfs_pkg;

    // Configuration port.
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // Register indexes (byte address divided by four).
    localparam logic [CFG_IDX_W-1:0] REG_BOX    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    // Register widths and reset values.
    localparam int BOX_REG_W  = 4;
    localparam int SIZE_REG_W = 11;
    localparam logic [BOX_REG_W-1:0]  BOX_RESET  = 4'd3;
    localparam logic [SIZE_REG_W-1:0] SIZE_RESET = 11'd1024;

    // Stream payload layout.
    localparam int PIX_W       = 16;
    localparam int COORD_W     = 10;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_FIELD_W = 2 * COORD_W + PIX_W;
    localparam int OUT_DATA_W  = 40;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_FLUSH,
        ST_DIV,
        ST_DONE
    } bfs_state_t;

    // Shared arithmetic unit operations.
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

endpackage

`default_nettype wire

// ===== rtl/bfs_ram.sv =====
// ============================================================================
// bfs_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ============================================================================
`default_nettype none

module bfs_ram #(
    parameter  int DATA_W = 16,
    parameter  int DEPTH  = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/bfs_alu.sv =====
// ============================================================================
// bfs_alu
// Shared adder/subtractor. It accumulates window pixels and performs the
// trial subtraction of each division step.
// ============================================================================
`default_nettype none

module bfs_alu #(
    parameter int W = 24
) (
    input  bfs_pkg::alu_op_t op,
    input  logic [W-1:0]     a,
    input  logic [W-1:0]     b,
    output logic [W-1:0]     res,
    output logic             carry
);

    import bfs_pkg::*;

    // For a subtraction the carry bit is the borrow: set when a < b.
    always_comb begin
        unique case (op)
            ALU_ADD: {carry, res} = {1'b0, a} + {1'b0, b};
            ALU_SUB: {carry, res} = {1'b0, a} - {1'b0, b};
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/box_filter_smoothing.sv =====
// ============================================================================
// box_filter_smoothing
// Streaming 2-D boxcar mean filter on 16-bit unsigned pixels in raster order.
// ============================================================================
// Pixels enter on the s_ stream, one per transfer, with s_tuser marking the
// first pixel of a frame. Every pixel is written into a line store of MAX_BOX
// rows; when the B x B box ending at that pixel lies inside the image, the
// block sends its centre coordinates and the truncated mean of the box on the
// m_ stream. B is the box side register with bit 0 forced on, capped at the
// largest odd value not above MAX_BOX. A pixel that completes no box leaves
// the block ready for the next one; a pixel that completes a box keeps it
// busy. The window is read one pixel per cycle through the single read port
// of the line store and summed in the shared adder, which then produces the
// SUM_W-bit quotient one bit per cycle by restoring division, where SUM_W is
// the width of the window sum (24 with the default parameters). A stalled
// result register keeps the block busy while m_tready stays low. The line
// store is not cleared after reset; configuration is to be written through
// the APB port only while the block is idle; the block does not enforce this.
// ============================================================================
`default_nettype none

module box_filter_smoothing #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_BOX    = 15
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bfs_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [bfs_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [bfs_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    // Pixel stream in
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bfs_pkg::IN_DATA_W-1:0]    s_tdata,   // [15:0] pixel_value
    input  logic                             s_tuser,   // [0] frame_start
    // Result stream out
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [9:0] out_column, [19:10] out_row, [35:20] mean_value, [39:36] zero
    output logic [bfs_pkg::OUT_DATA_W-1:0]   m_tdata
);

    import bfs_pkg::*;

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WCNT_W    = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int HCNT_W    = $clog2(MAX_HEIGHT + 1);
    localparam int SLOT_W    = $clog2(MAX_BOX);
    localparam int BOX_W     = $clog2(MAX_BOX + 1);
    localparam int BOX_LIMIT = MAX_BOX - 1 + (MAX_BOX % 2);
    localparam int DEPTH     = MAX_BOX * (1 << COL_W);
    localparam int ADDR_W    = SLOT_W + COL_W;
    localparam int SQ_W      = $clog2(BOX_LIMIT * BOX_LIMIT + 1);
    localparam int SUM_W     = $clog2(BOX_LIMIT * BOX_LIMIT * ((1 << PIX_W) - 1) + 1);
    localparam int DCNT_W    = $clog2(SUM_W + 1);

    // Next line store slot, wrapping at the number of rows kept.
    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(MAX_BOX - 1)) begin
            r = '0;
        end else begin
            r = s + SLOT_W'(1);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic [BOX_REG_W-1:0]  box_reg;
    logic [SIZE_REG_W-1:0] width_reg;
    logic [SIZE_REG_W-1:0] height_reg;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic                  cfg_wr;

    logic [WCNT_W-1:0]     w_eff;
    logic [HCNT_W-1:0]     h_eff;
    logic [BOX_W-1:0]      b_eff;
    logic [BOX_W-1:0]      bm1;
    logic [BOX_W-1:0]      half;
    logic [BOX_REG_W-1:0]  b_odd;

    logic [COL_W-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;

    logic [COL_W-1:0]      c0, cur_col;
    logic [ROW_W-1:0]      r0, cur_row;
    logic [SLOT_W-1:0]     s0, s1, cur_slot;
    logic [COL_W-1:0]      c1;
    logic [HCNT_W-1:0]     r1;
    logic [WCNT_W-1:0]     col_plus;
    logic [HCNT_W-1:0]     row_plus;
    logic                  win_full;
    logic [SLOT_W-1:0]     slot_start;

    bfs_state_t            state_reg, state_next;
    logic                  in_xfer;
    logic                  rd_issue;
    logic                  div_load;
    logic                  div_step;
    logic                  out_load;
    logic                  last_issue;
    alu_op_t               alu_op;

    logic [BOX_W-1:0]      i_reg;
    logic [BOX_W-1:0]      j_reg;
    logic [BOX_W-1:0]      bm1_reg;
    logic [SLOT_W-1:0]     slot_rd_reg;
    logic [COL_W-1:0]      col_start_reg;
    logic [SQ_W-1:0]       div_reg;
    logic [COORD_W-1:0]    out_col_reg;
    logic [COORD_W-1:0]    out_row_reg;
    logic                  rd_valid_reg;
    logic [SUM_W-1:0]      acc_reg;
    logic [SUM_W-1:0]      quo_reg;
    logic [SQ_W-1:0]       rem_reg;
    logic [DCNT_W-1:0]     dcnt_reg;
    logic [SQ_W:0]         shifted;

    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;
    logic [PIX_W-1:0]      rd_data;

    logic [SUM_W-1:0]      alu_a;
    logic [SUM_W-1:0]      alu_b;
    logic [SUM_W-1:0]      alu_res;
    logic                  alu_carry;

    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_reg    <= BOX_RESET;
            width_reg  <= SIZE_RESET;
            height_reg <= SIZE_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_BOX:    box_reg    <= pwdata[BOX_REG_W-1:0];
                REG_WIDTH:  width_reg  <= pwdata[SIZE_REG_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[SIZE_REG_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_BOX:    prdata = CFG_DATA_W'(box_reg);
            REG_WIDTH:  prdata = CFG_DATA_W'(width_reg);
            REG_HEIGHT: prdata = CFG_DATA_W'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // Effective sizes: zero acts as one, values beyond the maxima saturate,
    // and the box side is odd and capped.
    always_comb begin
        if (width_reg == '0) begin
            w_eff = WCNT_W'(1);
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = WCNT_W'(MAX_WIDTH);
        end else begin
            w_eff = WCNT_W'(width_reg);
        end

        if (height_reg == '0) begin
            h_eff = HCNT_W'(1);
        end else if (32'(height_reg) > 32'(MAX_HEIGHT)) begin
            h_eff = HCNT_W'(MAX_HEIGHT);
        end else begin
            h_eff = HCNT_W'(height_reg);
        end

        b_odd = box_reg | BOX_REG_W'(1);
        if (32'(b_odd) > 32'(BOX_LIMIT)) begin
            b_eff = BOX_W'(BOX_LIMIT);
        end else begin
            b_eff = BOX_W'(b_odd);
        end
        bm1  = b_eff - BOX_W'(1);
        half = b_eff >> 1;
    end

    // ------------------------------------------------------------------------
    // Position of the incoming pixel and counter update
    // ------------------------------------------------------------------------
    always_comb begin
        // A frame start restarts the raster.
        c0 = s_tuser ? '0 : col_reg;
        r0 = s_tuser ? '0 : row_reg;
        s0 = s_tuser ? '0 : slot_reg;

        // A column left beyond a narrowed width moves to the next row.
        if (WCNT_W'(c0) >= w_eff) begin
            c1 = '0;
            r1 = HCNT_W'(r0) + HCNT_W'(1);
            s1 = slot_inc(s0);
        end else begin
            c1 = c0;
            r1 = HCNT_W'(r0);
            s1 = s0;
        end

        cur_col = c1;
        if (r1 >= h_eff) begin
            cur_row  = '0;
            cur_slot = '0;
        end else begin
            cur_row  = r1[ROW_W-1:0];
            cur_slot = s1;
        end

        // Counters after this pixel, wrapping at the end of a row and frame.
        col_plus = WCNT_W'(cur_col) + WCNT_W'(1);
        row_plus = HCNT_W'(cur_row) + HCNT_W'(1);
        if (col_plus >= w_eff) begin
            col_next = '0;
            if (row_plus >= h_eff) begin
                row_next  = '0;
                slot_next = '0;
            end else begin
                row_next  = row_plus[ROW_W-1:0];
                slot_next = slot_inc(cur_slot);
            end
        end else begin
            col_next  = col_plus[COL_W-1:0];
            row_next  = cur_row;
            slot_next = cur_slot;
        end

        win_full = (32'(cur_col) + 32'd1 >= 32'(b_eff)) &&
                   (32'(cur_row) + 32'd1 >= 32'(b_eff));

        // Slot of the top row of the box.
        if (32'(cur_slot) >= 32'(bm1)) begin
            slot_start = SLOT_W'(32'(cur_slot) - 32'(bm1));
        end else begin
            slot_start = SLOT_W'(32'(cur_slot) + 32'(MAX_BOX) - 32'(bm1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end else if (in_xfer) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    assign last_issue = (i_reg == bm1_reg) && (j_reg == bm1_reg);
    assign in_xfer    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer && win_full) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (last_issue) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (dcnt_reg == DCNT_W'(SUM_W - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs of each state.
    always_comb begin
        s_tready = 1'b0;
        rd_issue = 1'b0;
        div_load = 1'b0;
        div_step = 1'b0;
        out_load = 1'b0;
        alu_op   = ALU_ADD;
        unique case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_SUM:   rd_issue = 1'b1;
            ST_FLUSH: div_load = 1'b1;
            ST_DIV: begin
                div_step = 1'b1;
                alu_op   = ALU_SUB;
            end
            ST_DONE:  out_load = !m_valid_reg || m_tready;
            default:  ;
        endcase
    end

    // ------------------------------------------------------------------------
    // Window walk: one line store read per cycle
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            i_reg         <= '0;
            j_reg         <= '0;
            bm1_reg       <= bm1;
            slot_rd_reg   <= slot_start;
            col_start_reg <= COL_W'(32'(cur_col) - 32'(bm1));
            div_reg       <= SQ_W'(32'(b_eff) * 32'(b_eff));
            out_col_reg   <= COORD_W'(32'(cur_col) - 32'(half));
            out_row_reg   <= COORD_W'(32'(cur_row) - 32'(half));
        end else if (rd_issue) begin
            if (j_reg == bm1_reg) begin
                j_reg       <= '0;
                i_reg       <= i_reg + BOX_W'(1);
                slot_rd_reg <= slot_inc(slot_rd_reg);
            end else begin
                j_reg <= j_reg + BOX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= rd_issue;
        end
    end

    assign wr_addr = {cur_slot, cur_col};
    assign rd_addr = {slot_rd_reg, col_start_reg + COL_W'(j_reg)};

    bfs_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (DEPTH)
    ) u_line_store (
        .clk     (aclk),
        .wr_en   (in_xfer),
        .wr_addr (wr_addr),
        .wr_data (s_tdata[PIX_W-1:0]),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------------
    // Shared adder: window sum, then restoring division by B*B
    // ------------------------------------------------------------------------
    assign shifted = {rem_reg, quo_reg[SUM_W-1]};

    always_comb begin
        if (alu_op == ALU_SUB) begin
            alu_a = SUM_W'(shifted);
            alu_b = SUM_W'(div_reg);
        end else begin
            alu_a = acc_reg;
            alu_b = SUM_W'(rd_data);
        end
    end

    bfs_alu #(
        .W (SUM_W)
    ) u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .res   (alu_res),
        .carry (alu_carry)
    );

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            acc_reg <= '0;
        end else if (rd_valid_reg) begin
            acc_reg <= alu_res;
        end
    end

    // The last read is added on the way into the dividend register.
    always_ff @(posedge aclk) begin
        if (div_load) begin
            quo_reg  <= alu_res;
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end else if (div_step) begin
            quo_reg  <= {quo_reg[SUM_W-2:0], ~alu_carry};
            rem_reg  <= alu_carry ? shifted[SQ_W-1:0] : alu_res[SQ_W-1:0];
            dcnt_reg <= dcnt_reg + DCNT_W'(1);
        end
    end

    // ------------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= OUT_DATA_W'({quo_reg[PIX_W-1:0], out_row_reg, out_col_reg});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

// ===== rtl/bfs_checker.sv =====
// ============================================================================
// bfs_checker
// Port-level checks of the box filter, bound to its top level.
// ============================================================================
`default_nettype none

`include "assert_macros.svh"

module bfs_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [bfs_pkg::OUT_DATA_W-1:0] m_tdata
);

    import bfs_pkg::*;

    // A result that is not taken stays offered unchanged.
    `BFS_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // Reset leaves the block ready for a pixel with no result pending.
    `BFS_ASSERT_NR(a_reset_state, aclk, !aresetn |=> s_tready && !m_tvalid, "wrong state after reset")

    // A new result appears only as the sequencer returns to accepting pixels.
    `BFS_ASSERT(a_out_idle, aclk, aresetn, $rose(m_tvalid) |-> s_tready, "result raised while busy")

    // The padding above the result fields is always zero.
    `BFS_ASSERT(a_pad_zero, aclk, aresetn, m_tvalid |-> m_tdata[OUT_DATA_W-1:OUT_FIELD_W] == '0, "non-zero padding in result")

endmodule

bind box_filter_smoothing bfs_checker u_bfs_checker (.*);

`default_nettype wire
